// File: rtl/sofr_pkg.sv
// Shared constants for the second-order RK4 filter.
`timescale 1ns / 1ps
package sofr_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int STATE_WIDTH_DEF  = 48;

  // field and register widths
  localparam int FC_W       = 15;
  localparam int RES_W      = 15;
  localparam int FS_W       = 18;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;

  // coefficient and divider widths (Q.32, independent of state width)
  localparam int COEF_W     = 37;
  localparam int DIV_NUM_W  = 49;
  localparam int DIV_DEN_W  = 18;
  localparam int MUL_CHUNK_W = 16;

  localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;

  localparam logic [FC_W-1:0]  FC_MIN   = 15'd1;
  localparam logic [FC_W-1:0]  FC_MAX   = 15'd16000;
  localparam logic [RES_W-1:0] RES_MIN  = 15'd154;
  localparam logic [RES_W-1:0] RES_MAX  = 15'd25600;
  localparam logic [FS_W-1:0]  FS_MIN   = 18'd8000;
  localparam logic [FS_W-1:0]  FS_MAX   = 18'd192000;
  localparam logic [FS_W-1:0]  FS_RESET = 18'd48000;

  localparam logic [MODE_W-1:0] MODE_LP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE = 1'b1;

endpackage

// File: rtl/sofr_mul.sv
// Shared multi-cycle unsigned multiplier, one 16-bit digit of b per cycle.
`timescale 1ns / 1ps
module sofr_mul #(
  parameter int W = sofr_pkg::STATE_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] prod_o
);
  import sofr_pkg::*;

  localparam int CH  = MUL_CHUNK_W;
  localparam int NCH = (W + CH - 1) / CH;
  localparam int BW  = NCH * CH;
  localparam int AW  = W + BW;
  localparam int CW  = $clog2(NCH + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          ppv_q, ppv_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  a_q, a_d;
  logic [BW-1:0] b_q, b_d;
  logic [W+CH-1:0] pp_q, pp_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [CH-1:0] digit;

  assign digit = b_q[BW-1 -: CH];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ppv_d  = ppv_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    pp_d   = pp_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      ppv_d  = 1'b0;
      cnt_d  = CW'(NCH);
      a_d    = a_i;
      b_d    = BW'(b_i);
      acc_d  = '0;
    end else if (busy_q) begin
      // most significant digit first, so the accumulator only shifts by a constant
      if (cnt_q != '0) begin
        pp_d  = (W+CH)'(a_q) * (W+CH)'(digit);
        b_d   = b_q << CH;
        cnt_d = cnt_q - 1'b1;
        ppv_d = 1'b1;
      end else begin
        ppv_d = 1'b0;
      end
      if (ppv_q) begin
        acc_d = (acc_q << CH) + AW'(pp_q);
      end
      if (cnt_q == '0 && ppv_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ppv_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ppv_q  <= ppv_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    pp_q  <= pp_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q[2*W-1:0];

endmodule

// File: rtl/sofr_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sofr_div #(
  parameter int NW = sofr_pkg::DIV_NUM_W,
  parameter int DW = sofr_pkg::DIV_DEN_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  import sofr_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/sofr_core.sv
// Sequencer and datapath: coefficients, drive and the four RK4 stages.
`timescale 1ns / 1ps
module sofr_core #(
  parameter int SAMPLE_WIDTH = sofr_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = sofr_pkg::STATE_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [sofr_pkg::MODE_W-1:0]      mode_i,
  input  logic [sofr_pkg::FS_W-1:0]        fs_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_i,
  input  logic [sofr_pkg::FC_W-1:0]        cutoff_hz_i,
  input  logic [sofr_pkg::RES_W-1:0]       resonance_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]   filtered_o
);
  import sofr_pkg::*;

  localparam int SW  = STATE_WIDTH;
  localparam int PW  = 2 * SW;
  localparam int SHU = 33 - SAMPLE_WIDTH;
  localparam logic [SW-1:0] RECIP3 = {SW{1'b1}} / 3;

  typedef logic signed [SW-1:0] st_t;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_W_MUL   = 5'd1;
  localparam logic [4:0] S_W_DIV   = 5'd2;
  localparam logic [4:0] S_WQ_DIV  = 5'd3;
  localparam logic [4:0] S_W2_MUL  = 5'd4;
  localparam logic [4:0] S_DRV     = 5'd5;
  localparam logic [4:0] S_DRV_MUL = 5'd6;
  localparam logic [4:0] S_ACC_V   = 5'd7;
  localparam logic [4:0] S_ACC_VM  = 5'd8;
  localparam logic [4:0] S_ACC_YM  = 5'd9;
  localparam logic [4:0] S_LVL     = 5'd10;
  localparam logic [4:0] S_D6_M    = 5'd11;
  localparam logic [4:0] S_D6_FIX  = 5'd12;
  localparam logic [4:0] S_SUM     = 5'd13;
  localparam logic [4:0] S_SUM2    = 5'd14;
  localparam logic [4:0] S_SLP     = 5'd15;
  localparam logic [4:0] S_PUSH    = 5'd16;

  function automatic st_t sat_w(input logic [SW:0] s);
    if (s[SW] != s[SW-1]) begin
      return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return s[SW-1:0];
  endfunction

  function automatic st_t sadd(input st_t a, input st_t b);
    return sat_w({a[SW-1], a} + {b[SW-1], b});
  endfunction

  function automatic st_t ssub(input st_t a, input st_t b);
    return sat_w({a[SW-1], a} - {b[SW-1], b});
  endfunction

  function automatic logic [SW-1:0] mag(input st_t a);
    return a[SW-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic st_t with_sign(input logic [SW-1:0] m, input logic neg);
    return neg ? (~m + 1'b1) : m;
  endfunction

  // round half away from zero on the magnitude
  function automatic st_t drnd(input st_t a, input int k);
    logic [SW:0] m;
    m = ({1'b0, mag(a)} + ((SW+1)'(1) << (k - 1))) >> k;
    return with_sign(m[SW-1:0], a[SW-1]);
  endfunction

  // Q.32 rounding of a magnitude product, then signed saturation
  function automatic st_t mulq_fin(input logic [PW-1:0] p, input logic neg);
    logic [PW-1:0] r;
    logic          hi;
    r  = p + {{(PW-32){1'b0}}, 32'h8000_0000};
    hi = |r[PW-1:SW+31];
    if (neg) begin
      return hi ? {1'b1, {(SW-1){1'b0}}} : with_sign(r[SW+31:32], 1'b1);
    end
    return hi ? {1'b0, {(SW-1){1'b1}}} : r[SW+31:32];
  endfunction

  // half of (|s| + 3), divided by three later gives |s|/6 rounded
  function automatic logic [SW-1:0] d6_pre(input st_t s);
    return (mag(s) + SW'(3)) >> 1;
  endfunction

  logic [4:0] state_q, state_d;
  logic [1:0] step_q, step_d;
  logic       d6sel_q, d6sel_d;
  logic       mneg_q, mneg_d;
  logic signed [SAMPLE_WIDTH-1:0] x_q, x_d, p_q, p_d, e_q, e_d;
  logic [RES_W-1:0]  res_q, res_d;
  logic [COEF_W-1:0] w_q, w_d, wq_q, wq_d;
  st_t w2_q, w2_d, drive_q, drive_d, t_q, t_d, arg_q, arg_d;
  st_t yv_q, yv_d, sum_q, sum_d, q6_q, q6_d, y_q, y_d, v_q, v_d;
  st_t a_q [4];
  st_t a_d [4];
  logic [SW-1:0] t6_q, t6_d;

  logic          mul_start, mul_done;
  logic [SW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p;
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;

  logic [FC_W-1:0]  fc_cl;
  logic [RES_W-1:0] res_cl;
  logic [FS_W-1:0]  fs_cl;
  st_t xs, ps, es, lp_in, bp_in, hp_in, hv, ya, va, mq, lvl_sum, sum_full, d6_src;
  logic [SW-1:0] q0;
  logic [SW+1:0] r6;
  logic [SW:0]   om;

  sofr_mul #(.W(SW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  sofr_div #(.NW(DIV_NUM_W), .DW(DIV_DEN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign fc_cl  = (cutoff_hz_i < FC_MIN) ? FC_MIN :
                  (cutoff_hz_i > FC_MAX) ? FC_MAX : cutoff_hz_i;
  assign res_cl = (resonance_i < RES_MIN) ? RES_MIN :
                  (resonance_i > RES_MAX) ? RES_MAX : resonance_i;
  assign fs_cl  = (fs_i < FS_MIN) ? FS_MIN : (fs_i > FS_MAX) ? FS_MAX : fs_i;

  assign xs    = x_q;
  assign ps    = p_q;
  assign es    = e_q;
  assign lp_in = xs <<< SHU;
  assign bp_in = (xs - ps) <<< SHU;
  assign hp_in = (xs - (ps <<< 1) + es) <<< SHU;

  assign hv = drnd(v_q, 1);
  assign mq = mulq_fin(mul_p, mneg_q);

  // stage arguments
  always_comb begin
    unique case (step_q)
      2'd0: begin
        ya = y_q;
        va = v_q;
      end
      2'd1: begin
        ya = sadd(y_q, hv);
        va = sadd(v_q, drnd(a_q[0], 1));
      end
      2'd2: begin
        ya = sadd(sadd(y_q, hv), drnd(a_q[0], 2));
        va = sadd(v_q, drnd(a_q[1], 1));
      end
      default: begin
        ya = sadd(sadd(y_q, v_q), drnd(a_q[1], 1));
        va = sadd(v_q, a_q[2]);
      end
    endcase
  end

  assign lvl_sum  = sadd(sadd(a_q[0], a_q[1]), a_q[2]);
  assign sum_full = sadd(sadd(sum_q, t_q), a_q[3]);
  assign d6_src   = (state_q == S_LVL) ? lvl_sum : sum_full;
  assign q0       = mul_p[PW-1:SW];
  assign r6       = {2'b00, t6_q} - (({2'b00, q6_q} << 1) + {2'b00, q6_q});

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    d6sel_d = d6sel_q;
    mneg_d  = mneg_q;
    x_d     = x_q;
    p_d     = p_q;
    e_d     = e_q;
    res_d   = res_q;
    w_d     = w_q;
    wq_d    = wq_q;
    w2_d    = w2_q;
    drive_d = drive_q;
    t_d     = t_q;
    arg_d   = arg_q;
    yv_d    = yv_q;
    sum_d   = sum_q;
    q6_d    = q6_q;
    y_d     = y_q;
    v_d     = v_q;
    t6_d    = t6_q;
    a_d     = a_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d       = sample_i;
          res_d     = res_cl;
          step_d    = 2'd0;
          mul_start = 1'b1;
          mul_a     = SW'(TWO_PI_Q32);
          mul_b     = SW'(fc_cl);
          state_d   = S_W_MUL;
        end
      end
      S_W_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = DIV_NUM_W'(mul_p) + DIV_NUM_W'(fs_cl >> 1);
          div_den   = DIV_DEN_W'(fs_cl);
          state_d   = S_W_DIV;
        end
      end
      S_W_DIV: begin
        if (div_done) begin
          w_d       = div_quo[COEF_W-1:0];
          div_start = 1'b1;
          div_num   = (DIV_NUM_W'(div_quo[COEF_W-1:0]) << 8) + DIV_NUM_W'(res_q >> 1);
          div_den   = DIV_DEN_W'(res_q);
          state_d   = S_WQ_DIV;
        end
      end
      S_WQ_DIV: begin
        if (div_done) begin
          wq_d      = div_quo[COEF_W-1:0];
          mul_start = 1'b1;
          mul_a     = SW'(w_q);
          mul_b     = SW'(w_q);
          mneg_d    = 1'b0;
          state_d   = S_W2_MUL;
        end
      end
      S_W2_MUL: begin
        if (mul_done) begin
          w2_d    = mq;
          state_d = S_DRV;
        end
      end
      S_DRV: begin
        unique case (mode_i)
          MODE_HP: begin
            drive_d = hp_in;
            state_d = S_ACC_V;
          end
          MODE_BP: begin
            mul_start = 1'b1;
            mul_a     = SW'(wq_q);
            mul_b     = mag(bp_in);
            mneg_d    = bp_in[SW-1];
            state_d   = S_DRV_MUL;
          end
          default: begin
            // lowpass, and the unused code behaves the same
            mul_start = 1'b1;
            mul_a     = w2_q;
            mul_b     = mag(lp_in);
            mneg_d    = lp_in[SW-1];
            state_d   = S_DRV_MUL;
          end
        endcase
      end
      S_DRV_MUL: begin
        if (mul_done) begin
          drive_d = mq;
          state_d = S_ACC_V;
        end
      end
      S_ACC_V: begin
        arg_d     = ya;
        mul_start = 1'b1;
        mul_a     = SW'(wq_q);
        mul_b     = mag(va);
        mneg_d    = va[SW-1];
        state_d   = S_ACC_VM;
      end
      S_ACC_VM: begin
        if (mul_done) begin
          t_d       = ssub(drive_q, mq);
          mul_start = 1'b1;
          mul_a     = w2_q;
          mul_b     = mag(arg_q);
          mneg_d    = arg_q[SW-1];
          state_d   = S_ACC_YM;
        end
      end
      S_ACC_YM: begin
        if (mul_done) begin
          a_d[step_q] = ssub(t_q, mq);
          if (step_q == 2'd3) begin
            state_d = S_LVL;
          end else begin
            step_d  = step_q + 2'd1;
            state_d = S_ACC_V;
          end
        end
      end
      S_LVL, S_SUM2: begin
        // divide by six: (|s|+3)/2 times a reciprocal of three, then one correction
        if (state_q == S_LVL) begin
          yv_d    = sadd(y_q, v_q);
          d6sel_d = 1'b0;
        end else begin
          d6sel_d = 1'b1;
        end
        t6_d      = d6_pre(d6_src);
        mneg_d    = d6_src[SW-1];
        mul_start = 1'b1;
        mul_a     = d6_pre(d6_src);
        mul_b     = RECIP3;
        state_d   = S_D6_M;
      end
      S_D6_M: begin
        if (mul_done) begin
          q6_d    = q0;
          state_d = S_D6_FIX;
        end
      end
      S_D6_FIX: begin
        q6_d    = with_sign((r6 >= (SW+2)'(3)) ? (q6_q + 1'b1) : q6_q, mneg_q);
        state_d = d6sel_q ? S_SLP : S_SUM;
      end
      S_SUM: begin
        y_d     = sadd(yv_q, q6_q);
        sum_d   = sadd(a_q[0], sadd(a_q[1], a_q[1]));
        t_d     = sadd(a_q[2], a_q[2]);
        state_d = S_SUM2;
      end
      S_SLP: begin
        v_d     = sadd(v_q, q6_q);
        e_d     = p_q;
        p_d     = x_q;
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= 2'd0;
      d6sel_q <= 1'b0;
      y_q     <= '0;
      v_q     <= '0;
      p_q     <= '0;
      e_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      d6sel_q <= d6sel_d;
      y_q     <= y_d;
      v_q     <= v_d;
      p_q     <= p_d;
      e_q     <= e_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mneg_q  <= mneg_d;
    x_q     <= x_d;
    res_q   <= res_d;
    w_q     <= w_d;
    wq_q    <= wq_d;
    w2_q    <= w2_d;
    drive_q <= drive_d;
    t_q     <= t_d;
    arg_q   <= arg_d;
    yv_q    <= yv_d;
    sum_q   <= sum_d;
    q6_q    <= q6_d;
    t6_q    <= t6_d;
    a_q     <= a_d;
  end

  // output: level scaled to sample units, rounded, saturated
  assign om = ({1'b0, mag(y_q)} + ((SW+1)'(1) << (SHU - 1))) >> SHU;

  always_comb begin
    if (|om[SW:SAMPLE_WIDTH-1]) begin
      filtered_o = y_q[SW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                             : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else begin
      filtered_o = y_q[SW-1] ? (~om[SAMPLE_WIDTH-1:0] + 1'b1) : om[SAMPLE_WIDTH-1:0];
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_PUSH);

endmodule

// File: rtl/second_order_filter_rk4.sv
// Second-order resonant filter, one RK4 step per sample: top level.
//
// Input stream s_axis: one audio sample with its cutoff and resonance per
// request. Output stream m_axis: one filtered sample per input request.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 filter mode, 1 sample rate); write only while the filter is idle.
//
// From acceptance to a valid output register, each sample takes two passes
// of the bit-serial divider for the coefficients and thirteen passes of the
// shared multiplier for w, w^2, the drive (skipped in highpass), the four
// stages and two divisions by six.
// The next request is taken in the cycle after the hand-over.
// s_axis_tready is high only while the sequencer is idle, so one sample is
// in flight at a time. The output register lets the next sample be accepted
// while a result waits; if the receiver still stalls when that next result
// is ready, the sequencer holds it until the register frees.
// Reset clears the filter state and input history, sets lowpass at 48 kHz
// and empties the output register.
`timescale 1ns / 1ps
module second_order_filter_rk4 #(
  parameter int SAMPLE_WIDTH = sofr_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = sofr_pkg::STATE_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample, cutoff_hz, resonance (lowest bits first), zero padded to bytes
  input  logic [((SAMPLE_WIDTH+sofr_pkg::FC_W+sofr_pkg::RES_W+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // filtered, zero padded to bytes
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [sofr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sofr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sofr_pkg::*;

  localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  logic [MODE_W-1:0] mode_q;
  logic [FS_W-1:0]   fs_q;
  logic              out_valid_q, out_valid_d;
  logic [SAMPLE_WIDTH-1:0] out_data_q;
  logic              res_valid, slot_free, load;
  logic signed [SAMPLE_WIDTH-1:0] res_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LP;
      fs_q   <= FS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        CFG_RATE: fs_q   <= cfg_data_i[FS_W-1:0];
        default: ;
      endcase
    end
  end

  sofr_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .fs_i        (fs_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .cutoff_hz_i (s_axis_tdata[SAMPLE_WIDTH +: FC_W]),
    .resonance_i (s_axis_tdata[SAMPLE_WIDTH+FC_W +: RES_W]),
    .res_valid_o (res_valid),
    .res_ready_i (slot_free),
    .filtered_o  (res_data)
  );

  assign slot_free = !out_valid_q || m_axis_tready;
  assign load      = res_valid && slot_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_data_q);

  // the sequencer never offers a result while it takes a new request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !res_valid)
    else $error("result offered while idle");

  // one sample in flight: ready drops after each accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while busy");

  // a result handed over must appear on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_axis_tvalid)
    else $error("result lost on hand-over");

endmodule

// File: sim/second_order_filter_rk4_test.sv
// Self-checking testbench for the RK4 second-order filter: directed and random samples.
`timescale 1ns / 1ps
module second_order_filter_rk4_test;
  import sofr_pkg::*;

  localparam longint ST_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ST_MIN = -ST_MAX - 1;
  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // sample [23:0], cutoff_hz [38:24], resonance [53:39], zero padded
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // filtered [23:0]
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  second_order_filter_rk4 DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // filter state as the block should hold it
  longint          y_level, y_slope, x_prev, x_prev2;
  logic [MODE_W-1:0] mode_q;
  logic [FS_W-1:0]   rate_q;

  logic signed [23:0] filtered_due[$];
  int errors, accepted, results_seen, hold_off;
  int send_idle_pct, recv_idle_pct;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint sat_st(longint x);
    if (x > ST_MAX) return ST_MAX;
    if (x < ST_MIN) return ST_MIN;
    return x;
  endfunction

  function automatic longint unsigned mag(longint a);
    return a < 0 ? 64'd0 - longint'(unsigned'(a)) : longint'(unsigned'(a));
  endfunction

  function automatic longint from_mag(bit neg, longint unsigned m);
    if (!neg) return m > I64_MAX ? I64_MAX : longint'(m);
    if (m > I64_MAX) return -I64_MAX - 1;
    return -longint'(m);
  endfunction

  function automatic longint unsigned uadd(longint unsigned a, longint unsigned b);
    return a > ~b ? ~64'd0 : a + b;
  endfunction

  function automatic longint q32_mul(longint a, longint b);
    longint unsigned ma, mb, ah, al, bh, bl, hh, m;
    ma = mag(a);
    mb = mag(b);
    ah = ma >> 32; al = ma & 64'hFFFF_FFFF;
    bh = mb >> 32; bl = mb & 64'hFFFF_FFFF;
    hh = ah * bh;
    if (hh >= 64'h8000_0000) begin
      m = ~64'd0;
    end else begin
      m = hh << 32;
      m = uadd(m, ah * bl);
      m = uadd(m, al * bh);
      m = uadd(m, (al * bl + 64'h8000_0000) >> 32);
    end
    return sat_st(from_mag((a < 0) != (b < 0), m));
  endfunction

  function automatic longint div_near(longint s, longint unsigned d);
    longint unsigned m, q, r;
    m = mag(s);
    q = m / d;
    r = m % d;
    if (r >= d - r) q++;
    return sat_st(from_mag(s < 0, q));
  endfunction

  function automatic longint adds(longint a, longint b);
    return sat_st(a + b);
  endfunction

  function automatic longint stage_accel(longint drv, longint wq, longint w2,
                                         longint y, longint v);
    return sat_st(sat_st(drv - q32_mul(wq, v)) - q32_mul(w2, y));
  endfunction

  // one RK4 step; returns the filtered sample and advances the state
  function automatic logic signed [23:0] filter_step(logic [23:0] smp,
                                                     logic [14:0] fc_in,
                                                     logic [14:0] q_in);
    longint x, w, wq, w2, drv, y, v, hv, a1, a2, a3, a4, sum, o;
    longint unsigned fs, fc, res;
    x = longint'($signed(smp));
    fs = rate_q; fc = fc_in; res = q_in;
    if (fs < FS_MIN) fs = FS_MIN;
    if (fs > FS_MAX) fs = FS_MAX;
    if (fc < FC_MIN) fc = FC_MIN;
    if (fc > FC_MAX) fc = FC_MAX;
    if (res < RES_MIN) res = RES_MIN;
    if (res > RES_MAX) res = RES_MAX;
    w = longint'((64'd26986075409 * fc + fs / 2) / fs);
    wq = longint'((longint'(unsigned'(w)) * 256 + res / 2) / res);
    w2 = q32_mul(w, w);
    if (mode_q == MODE_HP) drv = sat_st((x - 2 * x_prev + x_prev2) * 512);
    else if (mode_q == MODE_BP) drv = q32_mul(wq, sat_st((x - x_prev) * 512));
    else drv = q32_mul(w2, sat_st(x * 512));
    y = y_level;
    v = y_slope;
    hv = div_near(v, 2);
    a1 = stage_accel(drv, wq, w2, y, v);
    a2 = stage_accel(drv, wq, w2, adds(y, hv), adds(v, div_near(a1, 2)));
    a3 = stage_accel(drv, wq, w2, adds(adds(y, hv), div_near(a1, 4)),
                     adds(v, div_near(a2, 2)));
    a4 = stage_accel(drv, wq, w2, adds(adds(y, v), div_near(a2, 2)), adds(v, a3));
    y_level = adds(adds(y, v), div_near(adds(adds(a1, a2), a3), 6));
    sum = adds(adds(adds(a1, adds(a2, a2)), adds(a3, a3)), a4);
    y_slope = adds(v, div_near(sum, 6));
    x_prev2 = x_prev;
    x_prev = x;
    o = div_near(y_level, 512);
    if (o > 8388607) o = 8388607;
    if (o < -8388608) o = -8388608;
    return o[23:0];
  endfunction

  task automatic send_sample(logic [23:0] smp, logic [14:0] fc, logic [14:0] q);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, q, fc, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    filtered_due.push_back(filter_step(smp, fc, q));
    accepted++;
  endtask

  // drain and let the sequencer settle, tvalid low
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (filtered_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_MODE) mode_q = val[MODE_W-1:0];
    else rate_q = val[FS_W-1:0];
  endtask

  task automatic random_sample();
    logic [23:0] smp;
    logic [14:0] fc, q;
    int pick;
    pick = $urandom_range(99);
    smp = 24'($urandom);
    if (pick < 50) smp = 24'($signed(smp) >>> $urandom_range(10)); // quieter audio
    fc = (pick % 10 == 0) ? 15'($urandom) : 15'($urandom_range(16000, 20));
    q = (pick % 7 == 0) ? 15'($urandom) : 15'($urandom_range(25600, 154));
    send_sample(smp, fc, q);
  endtask

  // field extremes and clamp edges in every mode
  task automatic test_directed();
    logic [1:0] m;
    for (int i = 0; i < 3; i++) begin
      m = (i == 0) ? MODE_LP : (i == 1) ? MODE_HP : MODE_BP;
      write_reg(CFG_MODE, 18'(m));
      send_sample(24'h7FFFFF, 15'd0, 15'd0);
      send_sample(24'h800000, 15'd16000, 15'd153);
      send_sample(24'h000000, 15'd24000, 15'd154);
      send_sample(24'hFFFFFF, 15'd32767, 15'd25600);
      send_sample(24'h123456, 15'd1000, 15'd32767);
      send_sample(24'h000000, 15'd1, 15'd256);
      wait_idle();
    end
  endtask

  // unused mode code and rate clamps, including a runaway setting
  task automatic test_config_edges();
    write_reg(CFG_MODE, 18'd3);
    write_reg(CFG_RATE, 18'd0);
    for (int i = 0; i < 4; i++) send_sample(24'h400000, 15'd16000, 15'd154);
    wait_idle();
    write_reg(CFG_RATE, 18'h3FFFF);
    for (int i = 0; i < 6; i++) random_sample();
    wait_idle();
    write_reg(CFG_RATE, FS_MIN);
    for (int i = 0; i < 4; i++) random_sample();
    wait_idle();
    write_reg(CFG_RATE, FS_MAX);
    write_reg(CFG_MODE, MODE_LP);
    for (int i = 0; i < 30; i++) send_sample(24'h000000, 15'd100, 15'd181);
    wait_idle();
  endtask

  // receiver blocks for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_off = 3000;
    for (int i = 0; i < 20; i++) random_sample();
    wait_idle();
  endtask

  task automatic test_random(int n, int s_idle, int r_idle);
    logic [17:0] rates[5] = '{18'd8000, 18'd44100, 18'd48000, 18'd96000, 18'd192000};
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int blk = 0; blk < 4; blk++) begin
      write_reg(CFG_MODE, 18'($urandom_range(3)));
      write_reg(CFG_RATE, rates[$urandom_range(4)]);
      for (int i = 0; i < n / 4; i++) random_sample();
      wait_idle();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (filtered_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %0d", $signed(m_axis_tdata));
      end else begin
        logic signed [23:0] want;
        want = filtered_due.pop_front();
        if (m_axis_tdata !== want) begin
          errors++;
          if (errors <= 10)
            $display("filtered mismatch: expected %0d got %0d", want,
                     $signed(m_axis_tdata));
        end
      end
    end
  end

  // receiver stall, long hold-off counted in cycles
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #50_000_000;
    $display("second_order_filter_rk4_test: done, errors");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    y_level = 0; y_slope = 0; x_prev = 0; x_prev2 = 0;
    mode_q = MODE_LP;
    rate_q = FS_RESET;
    errors = 0; accepted = 0; results_seen = 0; hold_off = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_edges();
    test_random(620, 38, 77);
    test_backpressure();
    test_random(620, 77, 38);
    test_random(620, 0, 0);
    wait_idle();
    repeat (400) @(posedge clk_i);
    $display("covered: %0d samples sent, %0d results checked, all modes incl. unused code,",
             accepted, results_seen);
    $display("  rate and field clamps, runaway, long output stall; %0d mismatches", errors);
    if (errors == 0 && filtered_due.size() == 0) begin
      $display("second_order_filter_rk4_test: done, clean");
    end else begin
      $display("second_order_filter_rk4_test: done, errors");
    end
    $finish;
  end

endmodule
